// ===== hdl/mitl_pkg.sv =====
// ----------------------------------------------------------------------------
// mitl_pkg
// Shared types and constants for the memory-image text loader: error codes,
// register indexes, character codes and the parser state record.
// ----------------------------------------------------------------------------
package mitl_pkg;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BOUNDS     = 3'd1,
    ERR_HEX_IN_BIN = 3'd2,
    ERR_SYNTAX     = 3'd3,
    ERR_EARLY_END  = 3'd4
  } mitl_err_e;

  typedef enum logic [2:0] {
    REG_HEX_MODE    = 3'd0,
    REG_WORD_WIDTH  = 3'd1,
    REG_ARRAY_DEPTH = 3'd2,
    REG_ARRAY_BASE  = 3'd3,
    REG_START_ADDR  = 3'd4,
    REG_END_ADDR    = 3'd5
  } mitl_reg_e;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [6:0] WORD_WIDTH_MAX = 7'd64;

  typedef struct packed {
    logic [31:0] addr;
    logic        active;
    logic        in_num;
    logic        rd_addr;
    logic        skip_line;
    logic        skip_cmt;
    logic        pend_inc;
    logic [7:0]  prev_char;
    logic [63:0] acc;
    logic [31:0] line_no;
    mitl_err_e   err;
    logic [31:0] err_line;
  } mitl_state_t;

endpackage

// ===== hdl/memory_image_text_loader.sv =====
// ----------------------------------------------------------------------------
// memory_image_text_loader
// Parses a hex or binary memory-image text stream one character per item and
// emits one result item per character: an entry write, the latched error and
// a done flag on the end-of-file item.
// ----------------------------------------------------------------------------
// The block takes one character item in every clock cycle unless the result
// register is full and stalled, and returns one result item for each, which
// passes through the input register and then the result register; the parser
// state update is combinational between those registers. A load starts with
// the first item after reset or after an end-of-file item, from start_addr
// at line 1. Program the registers only while no item is in flight.
module memory_image_text_loader (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tuser,   // [0] func (1 = end of file)
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] write_index, [95:32] write_value, [98:96] error_code,
  // [130:99] error_line, [135:131] zero
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tuser,   // [0] write_enable
  output logic         m_axis_tlast,   // load_done
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mitl_pkg::*;

  // configuration registers
  logic        hex_mode_q;
  logic [6:0]  word_width_q;
  logic [31:0] array_depth_q, array_base_q, start_addr_q, end_addr_q;

  logic      cfg_wr;
  mitl_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = mitl_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q    <= 1'b1;
      word_width_q  <= 7'd32;
      array_depth_q <= 32'd1024;
      array_base_q  <= 32'd0;
      start_addr_q  <= 32'd0;
      end_addr_q    <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HEX_MODE:    hex_mode_q    <= pwdata[0];
        REG_WORD_WIDTH:  word_width_q  <= pwdata[6:0];
        REG_ARRAY_DEPTH: array_depth_q <= pwdata;
        REG_ARRAY_BASE:  array_base_q  <= pwdata;
        REG_START_ADDR:  start_addr_q  <= pwdata;
        REG_END_ADDR:    end_addr_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HEX_MODE:    prdata = {31'd0, hex_mode_q};
      REG_WORD_WIDTH:  prdata = {25'd0, word_width_q};
      REG_ARRAY_DEPTH: prdata = array_depth_q;
      REG_ARRAY_BASE:  prdata = array_base_q;
      REG_START_ADDR:  prdata = start_addr_q;
      REG_END_ADDR:    prdata = end_addr_q;
      default:         prdata = 32'd0;
    endcase
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_func_q;
  logic       advance;

  assign advance       = in_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_func_q <= s_axis_tuser;
    end
  end

  // character decode
  logic        is_digit, is_space;
  logic [3:0]  dig_val;
  logic [6:0]  width_eff;
  logic [63:0] width_mask;

  always_comb begin
    is_digit = 1'b1;
    dig_val  = 4'd0;
    if (in_char_q >= "0" && in_char_q <= "9") begin
      dig_val = 4'(in_char_q - "0");
    end else if (in_char_q >= "a" && in_char_q <= "f") begin
      dig_val = 4'(in_char_q - "a" + 8'd10);
    end else if (in_char_q >= "A" && in_char_q <= "F") begin
      dig_val = 4'(in_char_q - "A" + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_space = (in_char_q == CH_TAB) || (in_char_q == CH_SPACE) ||
                    (in_char_q == CH_CR)  || (in_char_q == CH_FF);

  assign width_eff  = (word_width_q == 7'd0) ? 7'd1 : word_width_q;
  assign width_mask = (width_eff >= WORD_WIDTH_MAX) ? {64{1'b1}}
                                                    : ~({64{1'b1}} << width_eff);

  // parser state update
  mitl_state_t state_q, state_d;
  logic        wr_en;
  logic [31:0] wr_idx;
  logic [63:0] wr_val, acc_base;
  logic        done;
  logic        out_of_range;

  always_comb begin
    state_d      = state_q;
    wr_en        = 1'b0;
    wr_idx       = 32'd0;
    wr_val       = 64'd0;
    done         = 1'b0;
    acc_base     = 64'd0;
    out_of_range = 1'b0;

    if (!state_q.active) begin
      state_d.addr      = start_addr_q;
      state_d.active    = 1'b1;
      state_d.in_num    = 1'b0;
      state_d.rd_addr   = 1'b0;
      state_d.skip_line = 1'b0;
      state_d.skip_cmt  = 1'b0;
      state_d.pend_inc  = 1'b0;
      state_d.prev_char = CH_SPACE;
      state_d.acc       = 64'd0;
      state_d.line_no   = 32'd1;
      state_d.err       = ERR_NONE;
      state_d.err_line  = 32'd0;
    end

    if (!in_func_q) begin
      if (state_d.err == ERR_NONE) begin
        if (in_char_q == CH_NL) begin
          state_d.line_no   = state_d.line_no + 32'd1;
          state_d.skip_line = 1'b0;
          if (state_d.in_num) state_d.rd_addr = 1'b0;
          state_d.in_num = 1'b0;
        end else if (is_space) begin
          if (state_d.in_num) state_d.rd_addr = 1'b0;
          state_d.in_num = 1'b0;
        end else if (state_d.skip_cmt && state_d.prev_char == CH_STAR &&
                     in_char_q == CH_SLASH) begin
          state_d.skip_cmt = 1'b0;
          if (state_d.in_num) state_d.rd_addr = 1'b0;
          state_d.in_num = 1'b0;
        end else if (!state_d.skip_line && !state_d.skip_cmt) begin
          if (state_d.prev_char == CH_SLASH && in_char_q == CH_STAR) begin
            state_d.skip_cmt = 1'b1;
          end else if (state_d.prev_char == CH_SLASH && in_char_q == CH_SLASH) begin
            state_d.skip_line = 1'b1;
          end else if (in_char_q == CH_SLASH || in_char_q == CH_UNDER) begin
            // slash may open a comment; underscore pads a number
          end else if (in_char_q == CH_AT) begin
            state_d.rd_addr  = 1'b1;
            state_d.in_num   = 1'b0;
            state_d.pend_inc = 1'b0;
          end else if (is_digit) begin
            // advance to the next entry on the first digit of a new word
            if (!state_d.in_num && state_d.pend_inc) begin
              state_d.addr     = state_d.addr + 32'd1;
              state_d.pend_inc = 1'b0;
            end
            if (state_d.rd_addr) begin
              state_d.addr   = {(state_d.in_num ? state_d.addr[27:0] : 28'd0), dig_val};
              state_d.in_num = 1'b1;
            end else begin
              state_d.pend_inc = 1'b1;
              out_of_range = ({1'b0, state_d.addr} < {1'b0, array_base_q}) ||
                             ({1'b0, state_d.addr} >= ({1'b0, array_base_q} +
                                                       {1'b0, array_depth_q}));
              if (out_of_range) begin
                state_d.err      = ERR_BOUNDS;
                state_d.err_line = state_d.line_no;
              end else if (!hex_mode_q && dig_val > 4'd1) begin
                state_d.err      = ERR_HEX_IN_BIN;
                state_d.err_line = state_d.line_no;
              end else begin
                acc_base = state_d.in_num ? state_d.acc : 64'd0;
                state_d.acc = (hex_mode_q ? {acc_base[59:0], dig_val}
                                          : {acc_base[62:0], dig_val[0]}) & width_mask;
                wr_en          = 1'b1;
                wr_idx         = state_d.addr - array_base_q;
                wr_val         = state_d.acc;
                state_d.in_num = 1'b1;
              end
            end
          end else begin
            state_d.err      = ERR_SYNTAX;
            state_d.err_line = state_d.line_no;
          end
        end
        state_d.prev_char = in_char_q;
      end
    end else begin
      if (state_d.pend_inc) begin
        state_d.addr     = state_d.addr + 32'd1;
        state_d.pend_inc = 1'b0;
      end
      if (state_d.err == ERR_NONE && end_addr_q != 32'hFFFF_FFFF &&
          state_d.addr != end_addr_q + 32'd1) begin
        state_d.err      = ERR_EARLY_END;
        state_d.err_line = state_d.line_no;
      end
      done           = 1'b1;
      state_d.active = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.addr      <= 32'd0;
      state_q.active    <= 1'b0;
      state_q.in_num    <= 1'b0;
      state_q.rd_addr   <= 1'b0;
      state_q.skip_line <= 1'b0;
      state_q.skip_cmt  <= 1'b0;
      state_q.pend_inc  <= 1'b0;
      state_q.prev_char <= CH_SPACE;
      state_q.acc       <= 64'd0;
      state_q.line_no   <= 32'd1;
      state_q.err       <= ERR_NONE;
      state_q.err_line  <= 32'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  logic         out_valid_q;
  logic [135:0] out_data_q;
  logic         out_we_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {5'd0, state_d.err_line, state_d.err, wr_val, wr_idx};
      out_we_q   <= wr_en;
      out_done_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_done_q;

  // checks
  a_write_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[98:96] == ERR_NONE))
    else $error("write issued while an error is latched");

  a_write_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
    else $error("end-of-file item carries a write");

  a_no_err_no_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[98:96] == ERR_NONE) |-> (m_axis_tdata[130:99] == 32'd0))
    else $error("error line set without an error");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.active && state_q.err != ERR_NONE) |=> (state_q.err == $past(state_q.err)))
    else $error("latched error changed within a load");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register is empty");

endmodule

// ===== tb/mitl_load_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mitl_load_checker
// Watches the character, result and register channels of the loader. Keeps
// its own copy of the settings and the parser state, works out the result of
// every accepted character item and compares each result item field by field.
// ----------------------------------------------------------------------------
module mitl_load_checker
  import mitl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tuser,   // [0] func (1 = end of file)
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] write_index, [95:32] write_value, [98:96] error_code,
  // [130:99] error_line, [135:131] zero
  input  logic [135:0] m_axis_tdata,
  input  logic         m_axis_tuser,   // [0] write_enable
  input  logic         m_axis_tlast,   // load_done
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int unsigned  mismatch_count_o,
  output int unsigned  pending_o
);

  typedef struct {
    logic        we;
    logic [31:0] idx;
    logic [63:0] val;
    mitl_err_e   err;
    logic [31:0] err_line;
    logic        done;
  } load_result_t;

  // settings
  logic        hex_mode_q;
  logic [6:0]  word_width_q;
  logic [31:0] depth_q;
  logic [31:0] base_q;
  logic [31:0] start_q;
  logic [31:0] end_q;

  // parser state
  logic [31:0] cur_addr;
  logic        load_active;
  logic        in_num;
  logic        rd_addr;
  logic        skip_line;
  logic        skip_cmt;
  logic        pend_inc;
  logic [7:0]  prev_ch;
  logic [63:0] acc;
  logic [31:0] line_no;
  mitl_err_e   err;
  logic [31:0] err_line;

  load_result_t load_results_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  pending_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending_count;

  function automatic void latch_error(mitl_err_e code);
    if (err == ERR_NONE) begin
      err      = code;
      err_line = line_no;
    end
  endfunction

  function automatic void close_number();
    if (in_num) rd_addr = 1'b0;
    in_num = 1'b0;
  endfunction

  function automatic void parse_char(input logic [7:0] c, inout load_result_t r);
    int          v;
    logic [32:0] limit;
    logic [63:0] mask;
    if (c >= "0" && c <= "9") v = int'(c - "0");
    else if (c >= "a" && c <= "f") v = int'(c - "a") + 10;
    else if (c >= "A" && c <= "F") v = int'(c - "A") + 10;
    else v = -1;
    limit = {1'b0, base_q} + {1'b0, depth_q};
    if (word_width_q >= WORD_WIDTH_MAX) mask = '1;
    else if (word_width_q == 7'd0) mask = 64'd1;
    else mask = (64'd1 << word_width_q) - 64'd1;

    if (c == CH_NL) begin
      line_no++;
      skip_line = 1'b0;
      close_number();
    end else if (c == CH_TAB || c == CH_SPACE || c == CH_CR || c == CH_FF) begin
      close_number();
    end else if (skip_cmt && prev_ch == CH_STAR && c == CH_SLASH) begin
      // a slash right after any star closes the block comment
      skip_cmt = 1'b0;
      close_number();
    end else if (!skip_line && !skip_cmt) begin
      if (prev_ch == CH_SLASH && c == CH_STAR) begin
        skip_cmt = 1'b1;
      end else if (prev_ch == CH_SLASH && c == CH_SLASH) begin
        skip_line = 1'b1;
      end else if (c == CH_AT) begin
        rd_addr  = 1'b1;
        in_num   = 1'b0;
        pend_inc = 1'b0;
      end else if (v >= 0) begin
        if (!in_num && pend_inc) begin
          cur_addr++;
          pend_inc = 1'b0;
        end
        if (rd_addr) begin
          if (!in_num) cur_addr = '0;
          cur_addr = (cur_addr << 4) + 32'(v);
          in_num   = 1'b1;
        end else begin
          pend_inc = 1'b1;
          if (cur_addr < base_q || {1'b0, cur_addr} >= limit) begin
            latch_error(ERR_BOUNDS);
          end else if (!hex_mode_q && v > 1) begin
            latch_error(ERR_HEX_IN_BIN);
          end else begin
            if (!in_num) acc = '0;
            acc    = ((hex_mode_q ? acc << 4 : acc << 1) + 64'(v)) & mask;
            r.we   = 1'b1;
            r.idx  = cur_addr - base_q;
            r.val  = acc;
            in_num = 1'b1;
          end
        end
      end else if (c != CH_SLASH && c != CH_UNDER) begin
        // a lone slash may open a comment and underscore pads, all else is bad
        latch_error(ERR_SYNTAX);
      end
    end
    prev_ch = c;
  endfunction

  function automatic load_result_t next_load_result(logic eof, logic [7:0] ch);
    load_result_t r;
    r.we   = 1'b0;
    r.idx  = '0;
    r.val  = '0;
    r.done = 1'b0;
    if (!load_active) begin
      cur_addr    = start_q;
      load_active = 1'b1;
      in_num      = 1'b0;
      rd_addr     = 1'b0;
      skip_line   = 1'b0;
      skip_cmt    = 1'b0;
      pend_inc    = 1'b0;
      prev_ch     = CH_SPACE;
      acc         = '0;
      line_no     = 32'd1;
      err         = ERR_NONE;
      err_line    = '0;
    end
    if (!eof) begin
      if (err == ERR_NONE) parse_char(ch, r);
    end else begin
      if (pend_inc) begin
        cur_addr++;
        pend_inc = 1'b0;
      end
      if (err == ERR_NONE && end_q != '1 && cur_addr != end_q + 32'd1)
        latch_error(ERR_EARLY_END);
      r.done      = 1'b1;
      load_active = 1'b0;
    end
    r.err      = err;
    r.err_line = err_line;
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", field, want, seen);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    load_result_t want;
    if (!rst_ni) begin
      hex_mode_q   = 1'b1;
      word_width_q = 7'd32;
      depth_q      = 32'd1024;
      base_q       = '0;
      start_q      = '0;
      end_q        = '1;
      cur_addr     = '0;
      load_active  = 1'b0;
      in_num       = 1'b0;
      rd_addr      = 1'b0;
      skip_line    = 1'b0;
      skip_cmt     = 1'b0;
      pend_inc     = 1'b0;
      prev_ch      = CH_SPACE;
      acc          = '0;
      line_no      = 32'd1;
      err          = ERR_NONE;
      err_line     = '0;
      load_results_q.delete();
      pending_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (mitl_reg_e'(paddr[4:2]))
          REG_HEX_MODE:    hex_mode_q   = pwdata[0];
          REG_WORD_WIDTH:  word_width_q = pwdata[6:0];
          REG_ARRAY_DEPTH: depth_q      = pwdata;
          REG_ARRAY_BASE:  base_q       = pwdata;
          REG_START_ADDR:  start_q      = pwdata;
          REG_END_ADDR:    end_q        = pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        load_results_q.push_back(next_load_result(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (load_results_q.size() == 0) begin
          $error("result item with no character item waiting");
          mismatch_count++;
        end else begin
          want = load_results_q.pop_front();
          check_field("write_enable", 64'(want.we), 64'(m_axis_tuser));
          check_field("write_index", 64'(want.idx), 64'(m_axis_tdata[31:0]));
          check_field("write_value", want.val, m_axis_tdata[95:32]);
          check_field("error_code", 64'(want.err), 64'(m_axis_tdata[98:96]));
          check_field("error_line", 64'(want.err_line), 64'(m_axis_tdata[130:99]));
          check_field("load_done", 64'(want.done), 64'(m_axis_tlast));
        end
      end
      pending_count = load_results_q.size();
    end
  end

endmodule

// ===== tb/tb_memory_image_text_loader.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_image_text_loader
// Feeds memory-image text to the loader: a few hand-made files, then phases of
// random settings, each loading several generated images, mostly well formed
// with comments, padding and load addresses, some with stray bytes or a wrong
// entry count. Both streams idle in random bursts; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_memory_image_text_loader;
  import mitl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned QUIET_AFTER  = 1250;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;     // [7:0] char_code
  logic         s_axis_tuser = 1'b0;   // [0] func (1 = end of file)
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] write_index, [95:32] write_value, [98:96] error_code,
  // [130:99] error_line, [135:131] zero
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;          // [0] write_enable
  logic         m_axis_tlast;          // load_done
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int unsigned  mismatch_count;
  int unsigned  pending_items;

  // settings as the generator sees them
  logic         hex_set = 1'b1;
  logic [31:0]  start_set;
  logic [31:0]  end_set;
  int unsigned  entries_set;

  logic [7:0]   image_q[$];
  int unsigned  items_sent = 0;
  logic         noise_on = 1'b0;
  logic         tx_bursty = 1'b0;
  logic         rx_bursty = 1'b1;
  logic         quiet_tail = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  memory_image_text_loader i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mitl_load_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_items)
  );

  // Offer one item and hold it until taken, then maybe idle for a burst.
  task automatic send_item(input logic eof, input logic [7:0] ch);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (!quiet_tail && tx_bursty && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input mitl_reg_e r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_items != 0);
    @(posedge clk_i);
  endtask

  task automatic push_char(input logic [7:0] ch);
    if (noise_on && $urandom_range(0, 29) == 0) image_q.push_back(8'($urandom()));
    image_q.push_back(ch);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) image_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] digit_char(logic [3:0] d);
    if (d < 4'd10) return "0" + 8'(d);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(d) - 8'd10;
  endfunction

  task automatic push_gap();
    int unsigned n;
    logic [7:0]  ch;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_char(CH_SPACE);
      4: push_char(CH_TAB);
      5: push_char(CH_CR);
      6: push_char(CH_FF);
      7: push_char(CH_NL);
      8: begin
        push_char(CH_SLASH);
        push_char(CH_SLASH);
        repeat (n) push_char(8'($urandom_range(32, 126)));
        push_char(CH_NL);
      end
      default: begin
        push_char(CH_SLASH);
        push_char(CH_STAR);
        repeat (n) begin
          ch = 8'($urandom_range(32, 126));
          // keep the comment from closing early
          if (ch == CH_SLASH) ch = CH_NL;
          push_char(ch);
        end
        push_char(CH_STAR);
        push_char(CH_SLASH);
      end
    endcase
  endtask

  task automatic build_image(input int unsigned n_entries, input logic with_at,
                             input logic [31:0] at_value);
    int unsigned n_dig;
    int unsigned max_dig;
    logic [39:0] at_wide;
    image_q.delete();
    if ($urandom_range(0, 3) == 0) push_gap();
    if (with_at) begin
      push_char(CH_AT);
      // digits past the eighth shift the top of the address out
      at_wide = {8'($urandom()), at_value};
      n_dig   = ($urandom_range(0, 9) == 0) ? 10 : 8;
      for (int k = int'(n_dig) - 1; k >= 0; k--) push_char(digit_char(4'(at_wide >> (4 * k))));
      push_gap();
    end
    for (int unsigned e = 0; e < n_entries; e++) begin
      if ($urandom_range(0, 9) == 0) max_dig = hex_set ? 18 : 70;
      else max_dig = hex_set ? 6 : 16;
      n_dig = $urandom_range(1, max_dig);
      repeat (n_dig) begin
        push_char(hex_set ? digit_char(4'($urandom())) : digit_char(4'($urandom_range(0, 1))));
        if ($urandom_range(0, 9) == 0) push_char(CH_UNDER);
      end
      if (e + 1 < n_entries || $urandom_range(0, 2) != 0) push_gap();
    end
  endtask

  task automatic send_image();
    foreach (image_q[i]) send_item(1'b0, image_q[i]);
    send_item(1'b1, 8'($urandom()));
  endtask

  initial begin : stimulus
    logic [6:0]  width_v;
    logic [31:0] base_v;
    logic [31:0] depth_v;
    logic [31:0] span;
    int unsigned directed_items;
    int unsigned kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty file; padding, both comment kinds and an entry past the array;
    // a stray character
    image_q.delete();
    send_image();
    image_q.delete();
    push_text("f_0 /**/A\n//x\n@4005 1");
    send_image();
    image_q.delete();
    push_text("!");
    send_image();
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_ITEMS) begin
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clk_i);

      hex_set = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: width_v = 7'd0;
        1: width_v = 7'd1;
        2: width_v = WORD_WIDTH_MAX;
        3: width_v = '1;
        4: width_v = 7'($urandom_range(65, 126));
        default: width_v = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 7))
        0: base_v = '0;
        1: base_v = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        2: base_v = $urandom();
        default: base_v = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 7))
        0: depth_v = 32'd1;
        1: depth_v = '1;
        2: depth_v = $urandom();
        default: depth_v = $urandom_range(1, 64);
      endcase
      entries_set = $urandom_range(1, 6);
      // land most images inside the array
      span = (depth_v > 32'd1000) ? 32'd1000 : depth_v - 32'd1;
      case ($urandom_range(0, 9))
        0: start_set = $urandom();
        1: start_set = '1;
        default: start_set = base_v + $urandom_range(0, span);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: end_set = '1;
        3: end_set = $urandom_range(0, 1) ? 32'd0 : $urandom();
        4: end_set = start_set + entries_set;
        default: end_set = start_set + entries_set - 1;
      endcase

      write_reg(REG_HEX_MODE, ($urandom() & ~32'd1) | 32'(hex_set));
      write_reg(REG_WORD_WIDTH, {25'($urandom()), width_v});
      write_reg(REG_ARRAY_DEPTH, depth_v);
      write_reg(REG_ARRAY_BASE, base_v);
      write_reg(REG_START_ADDR, start_set);
      write_reg(REG_END_ADDR, end_set);

      repeat ($urandom_range(1, 5)) begin
        kind      = $urandom_range(0, 9);
        tx_bursty = ($urandom_range(0, 2) != 0);
        noise_on  = (kind == 6 || kind == 7);
        case (kind)
          8: build_image(entries_set + $urandom_range(0, 2) - 1, 1'b0, start_set);
          9: build_image(entries_set, 1'b1, $urandom());
          default: build_image(entries_set, $urandom_range(0, 2) == 0, start_set);
        endcase
        send_image();
        if (items_sent - directed_items >= QUIET_AFTER) quiet_tail <= 1'b1;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_items == 0) begin
      $display("memory_image_text_loader regression: pass");
    end else begin
      $display("memory_image_text_loader regression: fail");
    end
    $finish;
  end

  // Result side: short random stalls, and now and then a long hold-off that
  // backs the block up into its input.
  initial begin : result_sink
    int unsigned cycle_no;
    int unsigned next_hold_at;
    int unsigned hold;
    cycle_no     = 0;
    next_hold_at = 400;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      hold = 0;
      if (!quiet_tail && cycle_no >= next_hold_at) begin
        hold         = 150;
        next_hold_at = next_hold_at + 1800;
      end else if (!quiet_tail && rx_bursty && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7);
      end else if ($urandom_range(0, 149) == 0) begin
        rx_bursty = ~rx_bursty;
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        cycle_no = cycle_no + hold;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      cycle_no++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("memory_image_text_loader regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mitl_pkg.sv
hdl/memory_image_text_loader.sv
tb/mitl_load_checker.sv
tb/tb_memory_image_text_loader.sv
